// File: rtl/core/tvm_pkg.sv
`default_nettype none
package tvm_pkg;

  typedef enum logic [4:0] {
    OP_MOV = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3, OP_DIV = 5'd4,
    OP_SWAP = 5'd5, OP_CMP = 5'd6, OP_AND = 5'd7, OP_OR = 5'd8, OP_XOR = 5'd9,
    OP_SHL = 5'd10, OP_SHR = 5'd11, OP_JMP = 5'd12, OP_JZ = 5'd13, OP_JP = 5'd14,
    OP_JN = 5'd15, OP_JNZ = 5'd16, OP_JNP = 5'd17, OP_JNN = 5'd18, OP_LDH = 5'd19,
    OP_LDL = 5'd20, OP_NOT = 5'd21, OP_STOP = 5'd22
  } op_t;

  // Data memory depth in words. Addresses wrap by truncation, so it stays a power of two.
  localparam int MEM_WORDS = 4096;

  localparam logic [1:0] KIND_IMM = 2'd0;
  localparam logic [1:0] KIND_REG = 2'd1;
  localparam logic [1:0] KIND_MEM = 2'd2;
  localparam logic [1:0] KIND_BAD = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_DIVERR = 2'd2;

  localparam logic [31:0] CC_ZERO = 32'h0000_0001;
  localparam logic [31:0] CC_NEG = 32'h8000_0000;
  localparam logic [3:0] FIRST_SECTORED = 4'hA;

  typedef struct packed {
    logic [4:0] operation;
    logic [1:0] kind_a;
    logic [31:0] operand_a;
    logic [1:0] kind_b;
    logic [31:0] operand_b;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] written_value;
    logic cc_zero;
    logic cc_negative;
    logic [31:0] ip_value;
  } result_t;

  typedef struct packed {
    logic start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;

  // Sign-extended sector read for registers 10..15.
  function automatic logic [31:0] sector_read(input logic [3:0] r, input logic [1:0] sec,
                                              input logic [31:0] v);
    logic [31:0] o;
    o = v;
    if (r >= FIRST_SECTORED) begin
      unique case (sec)
        2'd0: o = v;
        2'd1: o = {{24{v[7]}}, v[7:0]};
        2'd2: o = {{24{v[15]}}, v[15:8]};
        default: o = {{16{v[15]}}, v[15:0]};
      endcase
    end
    return o;
  endfunction

  function automatic logic [31:0] sector_write(input logic [3:0] r, input logic [1:0] sec,
                                               input logic [31:0] old, input logic [31:0] val);
    logic [31:0] o;
    o = val;
    if (r >= FIRST_SECTORED) begin
      unique case (sec)
        2'd0: o = val;
        2'd1: o = {old[31:8], val[7:0]};
        2'd2: o = {old[31:16], val[7:0], old[7:0]};
        default: o = {old[31:16], val[15:0]};
      endcase
    end
    return o;
  endfunction

  function automatic logic [31:0] cc_of(input logic [31:0] v);
    logic [31:0] o;
    o = 32'd0;
    if (v == 32'd0) o = CC_ZERO;
    else if (v[31]) o = CC_NEG;
    return o;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/tvm_stream_if.sv
`default_nettype none
interface tvm_stream_if #(parameter type payload_t = logic);
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/core/tvm_divider.sv
`default_nettype none
// Restoring signed divider, one quotient bit per cycle.
module tvm_divider (
  input wire logic clk,
  input wire logic rst,
  input wire tvm_pkg::div_req_t req,
  output tvm_pkg::div_rsp_t rsp
);
  logic [31:0] quo, rem, dvs;
  logic [5:0] cnt;
  logic busy, neg_q;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
      cnt <= 6'd0;
    end else begin
      if (req.start) begin
        rsp.done <= 1'b0;
        busy <= 1'b1;
        cnt <= 6'd32;
        quo <= req.dividend[31] ? -req.dividend : req.dividend;
        dvs <= req.divisor[31] ? -req.divisor : req.divisor;
        rem <= 32'd0;
        neg_q <= req.dividend[31] ^ req.divisor[31];
      end else if (busy) begin
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
          rsp.quotient <= neg_q ? -quo : quo;
          rsp.remainder <= rem;
        end else begin
          rsp.done <= 1'b0;
          cnt <= cnt - 6'd1;
          if (!trial[32]) begin
            rem <= trial[31:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= {rem[30:0], quo[31]};
            quo <= {quo[30:0], 1'b0};
          end
        end
      end else begin
        rsp.done <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/tvm_exec.sv
`default_nettype none
// Sequencer: reads operands from the register file and the data memory, computes,
// and writes the results back one per cycle.
module tvm_exec #(
  parameter int DS_INDEX = 0,
  parameter int IP_INDEX = 5,
  parameter int CC_INDEX = 8,
  parameter int AC_INDEX = 9
) (
  input wire logic clk,
  input wire logic rst,
  tvm_stream_if.sink in_ch,
  tvm_stream_if.source out_ch
);
  localparam int AW = $clog2(tvm_pkg::MEM_WORDS);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_RDA = 10'b0000000010, S_RDB = 10'b0000000100,
    S_WAITB = 10'b0000001000, S_CALC = 10'b0000010000, S_DIV = 10'b0000100000,
    S_WRA = 10'b0001000000, S_WRB = 10'b0010000000, S_WRAC = 10'b0100000000,
    S_OUT = 10'b1000000000
  } state_t;

  state_t state;
  tvm_pkg::item_t it;
  logic [31:0] regs [16];
  logic [31:0] mem [tvm_pkg::MEM_WORDS];
  logic [31:0] mem_q, va, vb, res, acv;
  logic [AW-1:0] mem_ra, mem_wa, addr_a, addr_b;
  logic mem_we;
  logic [31:0] mem_wd;
  logic [1:0] status;
  logic [31:0] wv;
  logic wr_a, wr_b, wr_ac, wr_cc;
  logic [31:0] cc_new;
  logic [63:0] prod;
  tvm_pkg::div_req_t dreq;
  tvm_pkg::div_rsp_t drsp;
  tvm_pkg::result_t rout;
  logic [31:0] ds_plus_a, ds_plus_b;

  tvm_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign ds_plus_a = regs[DS_INDEX] + it.operand_a;
  assign ds_plus_b = regs[DS_INDEX] + it.operand_b;
  assign addr_a = ds_plus_a[AW-1:0];
  assign addr_b = ds_plus_b[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  function automatic logic [31:0] reg_fetch(input logic [31:0] code,
                                            input logic [31:0] rv);
    return tvm_pkg::sector_read(code[3:0], code[5:4], rv);
  endfunction

  logic [4:0] op;
  logic is_alu, a_dst_ok;
  assign op = it.operation;
  assign is_alu = (op <= 5'(tvm_pkg::OP_DIV)) || (op >= 5'(tvm_pkg::OP_AND) &&
                  op <= 5'(tvm_pkg::OP_SHR));
  assign a_dst_ok = (it.kind_a == tvm_pkg::KIND_REG) || (it.kind_a == tvm_pkg::KIND_MEM);

  // Operand kinds that the operation does not accept, and undefined codes.
  logic bad_kind;
  always_comb begin
    bad_kind = 1'b0;
    if (is_alu) begin
      bad_kind = !a_dst_ok || it.kind_b == tvm_pkg::KIND_BAD;
    end else if (op == 5'(tvm_pkg::OP_SWAP)) begin
      bad_kind = !a_dst_ok ||
                 !(it.kind_b == tvm_pkg::KIND_REG || it.kind_b == tvm_pkg::KIND_MEM);
    end else if (op == 5'(tvm_pkg::OP_CMP)) begin
      bad_kind = it.kind_a == tvm_pkg::KIND_BAD || it.kind_b == tvm_pkg::KIND_BAD;
    end else if (op >= 5'(tvm_pkg::OP_JMP) && op <= 5'(tvm_pkg::OP_LDL)) begin
      bad_kind = it.kind_a == tvm_pkg::KIND_BAD;
    end else if (op == 5'(tvm_pkg::OP_NOT)) begin
      bad_kind = !a_dst_ok;
    end else if (op != 5'(tvm_pkg::OP_STOP)) begin
      bad_kind = 1'b1;
    end
  end

  // A zero divisor or the one quotient that does not fit in 32 bits.
  logic div_bad;
  assign div_bad = (vb == 32'd0) || (va == 32'h8000_0000 && vb == 32'hFFFF_FFFF);

  logic take;
  logic [31:0] cc;
  assign cc = regs[CC_INDEX];
  always_comb begin
    take = 1'b0;
    unique case (op)
      5'(tvm_pkg::OP_JMP): take = 1'b1;
      5'(tvm_pkg::OP_JZ): take = cc == tvm_pkg::CC_ZERO;
      5'(tvm_pkg::OP_JP): take = cc == 32'd0;
      5'(tvm_pkg::OP_JN): take = cc == tvm_pkg::CC_NEG;
      5'(tvm_pkg::OP_JNZ): take = !cc[0];
      5'(tvm_pkg::OP_JNP): take = cc == tvm_pkg::CC_NEG || cc == tvm_pkg::CC_ZERO;
      5'(tvm_pkg::OP_JNN): take = cc == 32'd0 || cc == tvm_pkg::CC_ZERO;
      default: take = 1'b0;
    endcase
  end

  // Memory port addressing per state.
  always_comb begin
    mem_ra = addr_a;
    if (state == S_RDB) mem_ra = addr_b;
    mem_we = 1'b0;
    mem_wa = addr_a;
    mem_wd = res;
    if (state == S_WRA && wr_a && it.kind_a == tvm_pkg::KIND_MEM) mem_we = 1'b1;
    if (state == S_WRB && wr_b && it.kind_b == tvm_pkg::KIND_MEM) begin
      mem_we = 1'b1;
      mem_wa = addr_b;
      mem_wd = va;
    end
  end

  assign prod = va * vb;
  assign dreq.dividend = va;
  assign dreq.divisor = vb;
  assign dreq.start = (state == S_CALC) && (op == 5'(tvm_pkg::OP_DIV)) &&
                      status == tvm_pkg::ST_OK && !div_bad;

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign rout.status = status;
  assign rout.written_value = wv;
  assign rout.cc_zero = regs[CC_INDEX][0];
  assign rout.cc_negative = regs[CC_INDEX][31];
  assign rout.ip_value = regs[IP_INDEX];
  assign out_ch.payload = rout;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < 16; i++) regs[i] <= 32'd0;
    end else begin
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          it <= in_ch.payload;
          state <= S_RDA;
        end
        S_RDA: begin
          // Validity and first operand (register or immediate) resolved here.
          status <= bad_kind ? tvm_pkg::ST_IGNORED : tvm_pkg::ST_OK;
          wv <= 32'd0;
          wr_a <= 1'b0; wr_b <= 1'b0; wr_ac <= 1'b0; wr_cc <= 1'b0;
          va <= (it.kind_a == tvm_pkg::KIND_REG) ?
                reg_fetch(it.operand_a, regs[it.operand_a[3:0]]) : it.operand_a;
          state <= S_RDB;
        end
        S_RDB: begin
          if (it.kind_a == tvm_pkg::KIND_MEM) va <= mem_q;
          vb <= (it.kind_b == tvm_pkg::KIND_REG) ?
                reg_fetch(it.operand_b, regs[it.operand_b[3:0]]) : it.operand_b;
          state <= S_WAITB;
        end
        S_WAITB: begin
          if (it.kind_b == tvm_pkg::KIND_MEM) vb <= mem_q;
          state <= S_CALC;
        end
        S_CALC: begin
          if (status == tvm_pkg::ST_OK && op == 5'(tvm_pkg::OP_DIV) && !div_bad)
            state <= S_DIV;
          else
            state <= S_WRA;
          if (status == tvm_pkg::ST_OK) begin
            unique case (op)
              5'(tvm_pkg::OP_MOV): begin res <= vb; wv <= vb; wr_a <= 1'b1; end
              5'(tvm_pkg::OP_ADD), 5'(tvm_pkg::OP_SUB), 5'(tvm_pkg::OP_MUL),
              5'(tvm_pkg::OP_AND), 5'(tvm_pkg::OP_OR), 5'(tvm_pkg::OP_XOR),
              5'(tvm_pkg::OP_SHL), 5'(tvm_pkg::OP_SHR), 5'(tvm_pkg::OP_NOT): begin
                logic [31:0] r;
                r = 32'd0;
                unique case (op)
                  5'(tvm_pkg::OP_ADD): r = va + vb;
                  5'(tvm_pkg::OP_SUB): r = va - vb;
                  5'(tvm_pkg::OP_MUL): r = prod[31:0];
                  5'(tvm_pkg::OP_AND): r = va & vb;
                  5'(tvm_pkg::OP_OR): r = va | vb;
                  5'(tvm_pkg::OP_XOR): r = va ^ vb;
                  5'(tvm_pkg::OP_SHL): r = (vb >= 32'd32) ? 32'd0 : va << vb[4:0];
                  5'(tvm_pkg::OP_SHR): r = (vb >= 32'd32) ? {32{va[31]}} :
                                        32'($signed(va) >>> vb[4:0]);
                  default: r = ~va;
                endcase
                res <= r; wv <= r; wr_a <= 1'b1; wr_cc <= 1'b1;
                cc_new <= tvm_pkg::cc_of(r);
              end
              5'(tvm_pkg::OP_DIV): begin
                if (div_bad) status <= tvm_pkg::ST_DIVERR;
              end
              5'(tvm_pkg::OP_SWAP): begin
                res <= vb; wv <= vb; wr_a <= 1'b1; wr_b <= 1'b1;
              end
              5'(tvm_pkg::OP_CMP): begin
                wr_cc <= 1'b1; cc_new <= tvm_pkg::cc_of(va - vb);
              end
              5'(tvm_pkg::OP_LDH): begin
                acv <= {va[15:0], regs[AC_INDEX][15:0]};
                wv <= {va[15:0], regs[AC_INDEX][15:0]}; wr_ac <= 1'b1;
              end
              5'(tvm_pkg::OP_LDL): begin
                acv <= {regs[AC_INDEX][31:16], va[15:0]};
                wv <= {regs[AC_INDEX][31:16], va[15:0]}; wr_ac <= 1'b1;
              end
              5'(tvm_pkg::OP_STOP): begin
                regs[IP_INDEX] <= regs[DS_INDEX]; wv <= regs[DS_INDEX];
              end
              default: begin
                if (take) begin
                  regs[IP_INDEX] <= va; wv <= va;
                end
              end
            endcase
          end
        end
        S_DIV: if (drsp.done) begin
          res <= drsp.quotient; wv <= drsp.quotient;
          acv <= drsp.remainder;
          wr_a <= 1'b1; wr_ac <= 1'b1; wr_cc <= 1'b1;
          cc_new <= tvm_pkg::cc_of(drsp.quotient);
          state <= S_WRA;
        end
        S_WRA: begin
          if (wr_a && it.kind_a == tvm_pkg::KIND_REG)
            regs[it.operand_a[3:0]] <= tvm_pkg::sector_write(it.operand_a[3:0],
              it.operand_a[5:4], regs[it.operand_a[3:0]], res);
          state <= S_WRB;
        end
        S_WRB: begin
          if (wr_b && it.kind_b == tvm_pkg::KIND_REG)
            regs[it.operand_b[3:0]] <= tvm_pkg::sector_write(it.operand_b[3:0],
              it.operand_b[5:4], regs[it.operand_b[3:0]], va);
          state <= S_WRAC;
        end
        S_WRAC: begin
          if (wr_ac) regs[AC_INDEX] <= acv;
          if (wr_cc) regs[CC_INDEX] <= cc_new;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/toy_vm_instruction_execute.sv
`default_nettype none
// Executes one decoded instruction of a small 32-bit virtual machine per beat.
// Input channel in_ch carries operation, operand kinds and operands; output
// channel out_ch carries one result beat per instruction: status, the value
// written, the condition code bits and the instruction pointer.
// The machine state sits in a 16-entry register file and a 4096-word data
// memory with a registered read, read and written back in sequence.
// One instruction is handled at a time. An ordinary instruction shows its
// result beat after operand reads through the single memory port, a compute
// state and the write-back states S_WRA, S_WRB and S_WRAC. The next
// instruction is accepted only once the result beat has been taken.
// div also waits in S_DIV for the bit-serial divider, one quotient bit per cycle.
// While the receiver stalls, the result beat is held and no input is taken.
// Synchronous reset clears the register file and control state; the data
// memory is not cleared and must be written before it is read.
module toy_vm_instruction_execute #(
  parameter int DS_INDEX = 0,
  parameter int IP_INDEX = 5,
  parameter int CC_INDEX = 8,
  parameter int AC_INDEX = 9
) (
  input wire logic clk,
  input wire logic rst,
  tvm_stream_if.sink in_ch,
  tvm_stream_if.source out_ch
);
  tvm_exec #(
    .DS_INDEX(DS_INDEX), .IP_INDEX(IP_INDEX),
    .CC_INDEX(CC_INDEX), .AC_INDEX(AC_INDEX)
  ) u_exec (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

// File: rtl/core/tvm_checker.sv
`default_nettype none
module tvm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] out_status,
  input wire logic [31:0] out_wv
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_status != 2'd3) else $error("bad status");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != 2'd0) |-> out_wv == 32'd0) else $error("wv not zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_wv)) else $error("result dropped");
endmodule

bind toy_vm_instruction_execute tvm_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.payload.status), .out_wv(out_ch.payload.written_value)
);
`default_nettype wire
